>>> hdl/arq_pkg.sv
// arq_pkg: shared types, codes and the CRC-16 helper for the stop-and-wait ARQ link.
// No dependencies; used by arq_ctrl, arq_dp and stop_and_wait_arq_link.
`default_nettype none

package arq_pkg;

    // defaults
    localparam int          FRAME_BYTES_DEF   = 32;
    localparam logic [5:0]  PAYLOAD_LIMIT_RST = 6'd32;
    localparam logic [15:0] TIMEOUT_RST       = 16'd1000;

    // CRC-16, poly 0x1021, init 0
    localparam logic [16:0] CRC_POLY  = 17'h11021;
    localparam logic [15:0] CRC_TOP   = 16'h8000;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    // configuration register indexes
    localparam logic CFG_LIMIT   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        OP_PAYLOAD = 2'd0,
        OP_LINE    = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_EVENT   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_SENT      = 4'd1,
        EV_TIMEOUT   = 4'd2,
        EV_CRC       = 4'd3,
        EV_SEQ       = 4'd4,
        EV_ACK       = 4'd5,
        EV_DELIVERED = 4'd6,
        EV_BUSY      = 4'd7,
        EV_OVERFLOW  = 4'd8
    } event_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_LATCH,
        A_PAY_HDR,
        A_PAY_DATA,
        A_PAY_CRCH,
        A_PAY_CRCL,
        A_IDX_CLR,
        A_EMIT_STORED,
        A_RX_STORE,
        A_RX_END,
        A_ACK_OK,
        A_EMIT_DLV,
        A_EMIT_ACK,
        A_TICK,
        A_EMIT_EVENT
    } action_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_PAY_HDR,
        S_PAY_DATA,
        S_PAY_CHECK,
        S_PAY_CRCH,
        S_PAY_CRCL,
        S_SEND_CHK,
        S_SEND_RD,
        S_SEND_EMIT,
        S_RX_STORE,
        S_RX_END,
        S_ACK_OK,
        S_DLV_RD,
        S_DLV_EMIT,
        S_ACK_TX,
        S_TICK,
        S_EVENT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        action_t action;
        logic    ev_load;
        event_t  ev;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic end_mark;
        logic awaiting;
        logic build_active;
        logic pay_done;
        logic send_empty;
        logic send_last;
        logic rx_overflow;
        logic rx_bad;
        logic hdr_match;
        logic rx_has_payload;
        logic dlv_last;
        logic ack_last;
        logic tick_fire;
        logic out_free;
    } stat_t;

    // one byte through the CRC register, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b & BYTE_MASK, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = 16'(({c, 1'b0}) ^ CRC_POLY);
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/arq_ctrl.sv
// arq_ctrl: sequencing state machine of the ARQ link.
// Depends on arq_pkg; drives arq_dp through cmd_t and reads stat_t.
`default_nettype none

module arq_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  arq_pkg::stat_t stat,
    output arq_pkg::cmd_t  cmd
);

    arq_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= arq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arq_pkg::S_IDLE:
                if (in_valid) state_next = arq_pkg::S_DISPATCH;
            arq_pkg::S_DISPATCH:
                case (stat.op)
                    arq_pkg::OP_PAYLOAD:
                        if (stat.awaiting)          state_next = arq_pkg::S_EVENT;
                        else if (!stat.build_active) state_next = arq_pkg::S_PAY_HDR;
                        else                         state_next = arq_pkg::S_PAY_DATA;
                    arq_pkg::OP_LINE:
                        state_next = arq_pkg::S_RX_STORE;
                    arq_pkg::OP_TICK:
                        state_next = stat.awaiting ? arq_pkg::S_TICK : arq_pkg::S_IDLE;
                    default:
                        state_next = arq_pkg::S_IDLE;
                endcase
            arq_pkg::S_PAY_HDR:   state_next = arq_pkg::S_PAY_DATA;
            arq_pkg::S_PAY_DATA:  state_next = arq_pkg::S_PAY_CHECK;
            arq_pkg::S_PAY_CHECK:
                state_next = stat.pay_done ? arq_pkg::S_PAY_CRCH : arq_pkg::S_IDLE;
            arq_pkg::S_PAY_CRCH:  state_next = arq_pkg::S_PAY_CRCL;
            arq_pkg::S_PAY_CRCL:  state_next = arq_pkg::S_SEND_CHK;
            arq_pkg::S_SEND_CHK:
                state_next = stat.send_empty ? arq_pkg::S_EVENT : arq_pkg::S_SEND_RD;
            arq_pkg::S_SEND_RD:   state_next = arq_pkg::S_SEND_EMIT;
            arq_pkg::S_SEND_EMIT:
                if (stat.out_free)
                    state_next = stat.send_last ? arq_pkg::S_IDLE : arq_pkg::S_SEND_RD;
            arq_pkg::S_RX_STORE:
                state_next = stat.end_mark ? arq_pkg::S_RX_END : arq_pkg::S_IDLE;
            arq_pkg::S_RX_END:
                if (stat.rx_overflow || stat.rx_bad)
                    state_next = arq_pkg::S_EVENT;
                else if (!stat.hdr_match)
                    state_next = stat.awaiting ? arq_pkg::S_EVENT : arq_pkg::S_SEND_CHK;
                else if (stat.awaiting)
                    state_next = arq_pkg::S_ACK_OK;
                else
                    state_next = stat.rx_has_payload ? arq_pkg::S_DLV_RD : arq_pkg::S_ACK_TX;
            arq_pkg::S_ACK_OK:    state_next = arq_pkg::S_EVENT;
            arq_pkg::S_DLV_RD:    state_next = arq_pkg::S_DLV_EMIT;
            arq_pkg::S_DLV_EMIT:
                if (stat.out_free)
                    state_next = stat.dlv_last ? arq_pkg::S_ACK_TX : arq_pkg::S_DLV_RD;
            arq_pkg::S_ACK_TX:
                if (stat.out_free && stat.ack_last) state_next = arq_pkg::S_IDLE;
            arq_pkg::S_TICK:
                state_next = stat.tick_fire ? arq_pkg::S_SEND_CHK : arq_pkg::S_IDLE;
            arq_pkg::S_EVENT:
                if (stat.out_free) state_next = arq_pkg::S_IDLE;
            default:
                state_next = arq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.action  = arq_pkg::A_NONE;
        cmd.ev_load = 1'b0;
        cmd.ev      = arq_pkg::EV_NONE;
        case (state_reg)
            arq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.action = arq_pkg::A_LATCH;
            end
            arq_pkg::S_DISPATCH:
            begin
                cmd.ev_load = 1'b1;
                cmd.ev      = arq_pkg::EV_BUSY;
            end
            arq_pkg::S_PAY_HDR:  cmd.action = arq_pkg::A_PAY_HDR;
            arq_pkg::S_PAY_DATA: cmd.action = arq_pkg::A_PAY_DATA;
            arq_pkg::S_PAY_CRCH: cmd.action = arq_pkg::A_PAY_CRCH;
            arq_pkg::S_PAY_CRCL:
            begin
                cmd.action  = arq_pkg::A_PAY_CRCL;
                cmd.ev_load = 1'b1;
                cmd.ev      = arq_pkg::EV_SENT;
            end
            arq_pkg::S_SEND_CHK: cmd.action = arq_pkg::A_IDX_CLR;
            arq_pkg::S_SEND_EMIT:
                if (stat.out_free) cmd.action = arq_pkg::A_EMIT_STORED;
            arq_pkg::S_RX_STORE: cmd.action = arq_pkg::A_RX_STORE;
            arq_pkg::S_RX_END:
            begin
                cmd.action  = arq_pkg::A_RX_END;
                cmd.ev_load = 1'b1;
                if (stat.rx_overflow)    cmd.ev = arq_pkg::EV_OVERFLOW;
                else if (stat.rx_bad)    cmd.ev = arq_pkg::EV_CRC;
                else if (!stat.hdr_match) cmd.ev = arq_pkg::EV_SEQ;
                else if (stat.awaiting)  cmd.ev = arq_pkg::EV_ACK;
                else                     cmd.ev = arq_pkg::EV_DELIVERED;
            end
            arq_pkg::S_ACK_OK: cmd.action = arq_pkg::A_ACK_OK;
            arq_pkg::S_DLV_EMIT:
                if (stat.out_free) cmd.action = arq_pkg::A_EMIT_DLV;
            arq_pkg::S_ACK_TX:
                if (stat.out_free) cmd.action = arq_pkg::A_EMIT_ACK;
            arq_pkg::S_TICK:
            begin
                cmd.action  = arq_pkg::A_TICK;
                cmd.ev_load = 1'b1;
                cmd.ev      = arq_pkg::EV_TIMEOUT;
            end
            arq_pkg::S_EVENT:
                if (stat.out_free) cmd.action = arq_pkg::A_EMIT_EVENT;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/arq_dp.sv
// arq_dp: datapath of the ARQ link: config, link state, frame memories, output register.
// Depends on arq_pkg; commanded by arq_ctrl.
`default_nettype none

module arq_dp #(
    parameter int FRAME_BYTES = arq_pkg::FRAME_BYTES_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  arq_pkg::cmd_t  cmd,
    output arq_pkg::stat_t stat,
    input  wire [1:0]      operation,
    input  wire [7:0]      data_byte,
    input  wire            end_mark,
    input  wire            cfg_we,
    input  wire            cfg_index,
    input  wire [15:0]     cfg_data,
    output logic           out_valid,
    input  wire            out_ready,
    output logic [1:0]     kind,
    output logic [7:0]     out_byte,
    output logic [3:0]     event_res,
    output logic           last
);

    localparam int CAP    = FRAME_BYTES + 3;
    localparam int CNT_W  = $clog2(CAP + 2);
    localparam int ADDR_W = $clog2(CAP);
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAP);
    localparam logic [CNT_W-1:0] FB_C    = CNT_W'(FRAME_BYTES);
    localparam logic [6:0]       FB7     = 7'(FRAME_BYTES);

    // configuration
    logic [5:0]  limit_cfg_reg;
    logic [15:0] timeout_cfg_reg;

    // link state
    logic             seq_reg, awaiting_reg, active_reg, out_valid_reg;
    logic [15:0]      wait_reg, bcrc_reg, rx_crc_reg;
    logic [CNT_W-1:0] st_len_reg, rx_cnt_reg, rx_len_reg, idx_reg;
    logic [1:0]       ack_idx_reg;

    // payload registers
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg, rx_hdr_reg, st_rd_reg, rx_rd_reg;
    logic        end_reg;
    arq_pkg::event_t ev_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  out_byte_reg;
    logic [3:0]  event_reg;
    logic        last_reg;

    // memories
    logic [7:0] st_mem [CAP];
    logic [7:0] rx_mem [CAP];

    // derived values
    logic [15:0] crc_in_byte, rx_crc_new, ack_crc, tick_lim, wait_inc;
    logic [7:0]  seq_byte, ack_byte;
    logic [6:0]  lim7, cfg7;
    logic        out_free, send_last, ack_last, tick_fire, emit;
    logic        st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [7:0]  st_wdata;

    assign seq_byte    = {7'd0, seq_reg};
    assign crc_in_byte = arq_pkg::crc_byte(bcrc_reg, byte_reg);
    assign rx_crc_new  = arq_pkg::crc_byte(rx_crc_reg, byte_reg);
    assign ack_crc     = arq_pkg::crc_byte(16'h0000, seq_byte);
    assign out_free    = !out_valid_reg || out_ready;
    assign send_last   = (idx_reg == st_len_reg - CNT_W'(1));
    assign ack_last    = (ack_idx_reg == 2'd2);
    assign tick_lim    = (timeout_cfg_reg == 16'd0) ? 16'd1 : timeout_cfg_reg;
    assign wait_inc    = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
    assign tick_fire   = (wait_inc >= tick_lim);

    // clamp payload limit to 1..FRAME_BYTES
    assign cfg7 = {1'b0, limit_cfg_reg};
    assign lim7 = (cfg7 == 7'd0) ? 7'd1 : ((cfg7 > FB7) ? FB7 : cfg7);

    // ACK frame bytes: sequence, CRC high, CRC low
    always_comb
    begin
        case (ack_idx_reg)
            2'd0:    ack_byte = seq_byte;
            2'd1:    ack_byte = ack_crc[15:8];
            default: ack_byte = ack_crc[7:0];
        endcase
    end

    // status to controller
    always_comb
    begin
        stat.op             = arq_pkg::op_t'(op_reg);
        stat.end_mark       = end_reg;
        stat.awaiting       = awaiting_reg;
        stat.build_active   = active_reg;
        stat.pay_done       = end_reg || !((7'(st_len_reg) - 7'd1) < lim7)
                              || (st_len_reg > FB_C);
        stat.send_empty     = active_reg || (st_len_reg == '0);
        stat.send_last      = send_last;
        stat.rx_overflow    = (rx_cnt_reg > CAP_C);
        stat.rx_bad         = (rx_cnt_reg < CNT_W'(3)) || (rx_crc_reg != 16'h0000);
        stat.hdr_match      = (rx_hdr_reg == seq_byte);
        stat.rx_has_payload = (rx_cnt_reg > CNT_W'(3));
        stat.dlv_last       = ((idx_reg + CNT_W'(3)) >= rx_len_reg);
        stat.ack_last       = ack_last;
        stat.tick_fire      = tick_fire;
        stat.out_free       = out_free;
    end

    // stored frame write port
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = st_len_reg[ADDR_W-1:0];
        st_wdata = byte_reg;
        case (cmd.action)
            arq_pkg::A_PAY_HDR:
            begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = seq_byte;
            end
            arq_pkg::A_PAY_DATA: st_we = (st_len_reg <= FB_C);
            arq_pkg::A_PAY_CRCH:
            begin
                st_we    = 1'b1;
                st_wdata = bcrc_reg[15:8];
            end
            arq_pkg::A_PAY_CRCL:
            begin
                st_we    = 1'b1;
                st_wdata = bcrc_reg[7:0];
            end
            arq_pkg::A_EMIT_ACK:
            begin
                st_we    = 1'b1;
                st_waddr = ADDR_W'(ack_idx_reg);
                st_wdata = ack_byte;
            end
            default: ;
        endcase
    end

    // memories, registered reads
    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[st_waddr] <= st_wdata;
        if (cmd.action == arq_pkg::A_RX_STORE && rx_cnt_reg < CAP_C)
            rx_mem[rx_cnt_reg[ADDR_W-1:0]] <= byte_reg;
        st_rd_reg <= st_mem[idx_reg[ADDR_W-1:0]];
        rx_rd_reg <= rx_mem[idx_reg[ADDR_W-1:0]];
    end

    // input capture, header byte, event code
    always_ff @(posedge clk)
    begin
        if (cmd.action == arq_pkg::A_LATCH)
        begin
            op_reg   <= operation;
            byte_reg <= data_byte;
            end_reg  <= end_mark;
        end
        if (cmd.action == arq_pkg::A_RX_STORE && rx_cnt_reg == '0)
            rx_hdr_reg <= byte_reg;
        if (cmd.ev_load)
            ev_reg <= cmd.ev;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_cfg_reg   <= arq_pkg::PAYLOAD_LIMIT_RST;
            timeout_cfg_reg <= arq_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                arq_pkg::CFG_LIMIT:   limit_cfg_reg   <= cfg_data[5:0];
                arq_pkg::CFG_TIMEOUT: timeout_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // link state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= 1'b0;
            awaiting_reg <= 1'b0;
            active_reg   <= 1'b0;
            wait_reg     <= '0;
            bcrc_reg     <= '0;
            rx_crc_reg   <= '0;
            st_len_reg   <= '0;
            rx_cnt_reg   <= '0;
            rx_len_reg   <= '0;
            idx_reg      <= '0;
            ack_idx_reg  <= '0;
        end
        else
        begin
            case (cmd.action)
                arq_pkg::A_PAY_HDR:
                begin
                    bcrc_reg   <= ack_crc;
                    st_len_reg <= CNT_W'(1);
                    active_reg <= 1'b1;
                end
                arq_pkg::A_PAY_DATA:
                    if (st_len_reg <= FB_C)
                    begin
                        bcrc_reg   <= crc_in_byte;
                        st_len_reg <= st_len_reg + CNT_W'(1);
                    end
                arq_pkg::A_PAY_CRCH:
                    st_len_reg <= st_len_reg + CNT_W'(1);
                arq_pkg::A_PAY_CRCL:
                begin
                    st_len_reg   <= st_len_reg + CNT_W'(1);
                    active_reg   <= 1'b0;
                    bcrc_reg     <= '0;
                    awaiting_reg <= 1'b1;
                    wait_reg     <= '0;
                end
                arq_pkg::A_IDX_CLR:
                    idx_reg <= '0;
                arq_pkg::A_EMIT_STORED, arq_pkg::A_EMIT_DLV:
                    idx_reg <= idx_reg + CNT_W'(1);
                arq_pkg::A_RX_STORE:
                begin
                    rx_crc_reg <= rx_crc_new;
                    if (rx_cnt_reg < CAP_C)
                        rx_cnt_reg <= rx_cnt_reg + CNT_W'(1);
                    else
                        rx_cnt_reg <= CAP_C + CNT_W'(1);
                end
                arq_pkg::A_RX_END:
                begin
                    rx_len_reg  <= rx_cnt_reg;
                    rx_cnt_reg  <= '0;
                    rx_crc_reg  <= '0;
                    idx_reg     <= CNT_W'(1);
                    ack_idx_reg <= '0;
                end
                arq_pkg::A_ACK_OK:
                begin
                    awaiting_reg <= 1'b0;
                    wait_reg     <= '0;
                    seq_reg      <= ~seq_reg;
                end
                arq_pkg::A_EMIT_ACK:
                begin
                    ack_idx_reg <= ack_idx_reg + 2'd1;
                    if (ack_last)
                    begin
                        st_len_reg <= CNT_W'(3);
                        active_reg <= 1'b0;
                        bcrc_reg   <= '0;
                        seq_reg    <= ~seq_reg;
                    end
                end
                arq_pkg::A_TICK:
                    wait_reg <= tick_fire ? 16'd0 : wait_inc;
                default: ;
            endcase
        end
    end

    // output register
    always_comb
    begin
        emit = (cmd.action == arq_pkg::A_EMIT_STORED) || (cmd.action == arq_pkg::A_EMIT_DLV)
            || (cmd.action == arq_pkg::A_EMIT_ACK) || (cmd.action == arq_pkg::A_EMIT_EVENT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.action)
            arq_pkg::A_EMIT_STORED:
            begin
                kind_reg     <= arq_pkg::KIND_TX;
                out_byte_reg <= st_rd_reg;
                last_reg     <= send_last;
                event_reg    <= send_last ? ev_reg : arq_pkg::EV_NONE;
            end
            arq_pkg::A_EMIT_DLV:
            begin
                kind_reg     <= arq_pkg::KIND_DELIVER;
                out_byte_reg <= rx_rd_reg;
                last_reg     <= 1'b0;
                event_reg    <= arq_pkg::EV_NONE;
            end
            arq_pkg::A_EMIT_ACK:
            begin
                kind_reg     <= arq_pkg::KIND_TX;
                out_byte_reg <= ack_byte;
                last_reg     <= ack_last;
                event_reg    <= ack_last ? ev_reg : arq_pkg::EV_NONE;
            end
            arq_pkg::A_EMIT_EVENT:
            begin
                kind_reg     <= arq_pkg::KIND_EVENT;
                out_byte_reg <= 8'h00;
                last_reg     <= 1'b1;
                event_reg    <= ev_reg;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = out_byte_reg;
    assign event_res = event_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> hdl/stop_and_wait_arq_link.sv
// Stop-and-wait ARQ link, top level: one item at a time.
// Each input transfer is taken only in the idle state; stored, delivered and ACK bytes and
// event-only results leave through one output register, and output stalls hold the link.
// Reset (rst_n, async) clears sequence, ACK wait, counters and config to defaults;
// frame memories are not cleared and need no clearing pass.
`default_nettype none

module stop_and_wait_arq_link #(
    parameter int FRAME_BYTES = arq_pkg::FRAME_BYTES_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire [1:0]  operation,
    input  wire [7:0]  data_byte,
    input  wire        end_mark,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [3:0] event_res,
    output logic       last,
    input  wire        cfg_we,
    input  wire        cfg_index,
    input  wire [15:0] cfg_data
);

    arq_pkg::cmd_t  cmd;
    arq_pkg::stat_t stat;

    // sequencer
    arq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    arq_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .operation (operation),
        .data_byte (data_byte),
        .end_mark  (end_mark),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_byte  (out_byte),
        .event_res (event_res),
        .last      (last)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench for stop_and_wait_arq_link: directed table, then random frame traffic.
// Depends on arq_pkg (op, kind, event and config codes, reset defaults) and the RTL top level only.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        logic       endm;
        logic       typed;
        logic [3:0] ev;
    } stim_row_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] ev;
        logic       fin;
    } link_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic        end_mark;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [3:0]  event_res;
    logic        last;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    stop_and_wait_arq_link dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .data_byte(data_byte), .end_mark(end_mark),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .out_byte(out_byte), .event_res(event_res), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the link state
    logic [5:0]  lim_reg;
    logic [15:0] tmo_reg;
    logic        seq_bit;
    logic        awaiting;
    logic [15:0] wait_cnt;
    logic [7:0]  tx_frame [0:34];
    int          tx_len;
    logic        building;
    logic [15:0] build_crc;
    logic [7:0]  rx_buf [0:34];
    int          rx_cnt;
    logic [15:0] rx_crc;

    link_res_t expected_q[$];
    stim_row_t stim_q[$];
    int        errors;
    int        items_sent;
    int        results_seen;
    int        send_idle;
    int        recv_idle;
    logic      cur_typed;
    logic [3:0] cur_ev;

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ 16'h1021;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void push_res(input logic [1:0] k, input logic [7:0] b,
                                     input logic [3:0] ev, input logic fin);
        link_res_t r;
        r.kind = k;
        r.data = b;
        r.ev   = ev;
        r.fin  = fin;
        expected_q.insert(expected_q.size(), r);
    endfunction

    // resend the stored frame, or a bare event when none is complete
    function automatic void resend_frame(input logic [3:0] ev);
        if (building || tx_len == 0)
        begin
            push_res(arq_pkg::KIND_EVENT, 8'h00, ev, 1'b1);
            return;
        end
        for (int i = 0; i < tx_len; i++)
            push_res(arq_pkg::KIND_TX, tx_frame[i],
                     (i == tx_len - 1) ? ev : arq_pkg::EV_NONE, i == tx_len - 1);
    endfunction

    function automatic void rx_frame_done();
        int          len;
        logic [15:0] c;
        len = rx_cnt;
        c = rx_crc;
        rx_cnt = 0;
        rx_crc = 16'h0000;
        if (len > 35)
            push_res(arq_pkg::KIND_EVENT, 8'h00, arq_pkg::EV_OVERFLOW, 1'b1);
        else if (len < 3 || c != 16'h0000)
            push_res(arq_pkg::KIND_EVENT, 8'h00, arq_pkg::EV_CRC, 1'b1);
        else if (rx_buf[0] != {7'd0, seq_bit})
        begin
            if (awaiting)
                push_res(arq_pkg::KIND_EVENT, 8'h00, arq_pkg::EV_SEQ, 1'b1);
            else
                resend_frame(arq_pkg::EV_SEQ);
        end
        else if (awaiting)
        begin
            awaiting = 1'b0;
            wait_cnt = 16'h0000;
            seq_bit = ~seq_bit;
            push_res(arq_pkg::KIND_EVENT, 8'h00, arq_pkg::EV_ACK, 1'b1);
        end
        else
        begin
            for (int i = 1; i + 2 < len; i++)
                push_res(arq_pkg::KIND_DELIVER, rx_buf[i], arq_pkg::EV_NONE, 1'b0);
            c = crc16_step(16'h0000, {7'd0, seq_bit});
            tx_frame[0] = {7'd0, seq_bit};
            tx_frame[1] = c[15:8];
            tx_frame[2] = c[7:0];
            tx_len = 3;
            building = 1'b0;
            build_crc = 16'h0000;
            seq_bit = ~seq_bit;
            for (int i = 0; i < 3; i++)
                push_res(arq_pkg::KIND_TX, tx_frame[i],
                         (i == 2) ? arq_pkg::EV_DELIVERED : arq_pkg::EV_NONE, i == 2);
        end
    endfunction

    // expected results of one accepted transfer
    function automatic void link_predict(input logic [1:0] op, input logic [7:0] b,
                                         input logic e);
        int lim;
        int tmo;
        if (op == arq_pkg::OP_PAYLOAD)
        begin
            if (awaiting)
            begin
                push_res(arq_pkg::KIND_EVENT, 8'h00, arq_pkg::EV_BUSY, 1'b1);
                return;
            end
            lim = (lim_reg < 1) ? 1 : ((lim_reg > 32) ? 32 : int'(lim_reg));
            if (!building)
            begin
                tx_frame[0] = {7'd0, seq_bit};
                build_crc = crc16_step(16'h0000, {7'd0, seq_bit});
                tx_len = 1;
                building = 1'b1;
            end
            if (tx_len <= 32)
            begin
                tx_frame[tx_len] = b;
                build_crc = crc16_step(build_crc, b);
                tx_len++;
            end
            if (!e && tx_len - 1 < lim && tx_len <= 32)
                return;
            tx_frame[tx_len] = build_crc[15:8];
            tx_frame[tx_len + 1] = build_crc[7:0];
            tx_len += 2;
            building = 1'b0;
            build_crc = 16'h0000;
            awaiting = 1'b1;
            wait_cnt = 16'h0000;
            resend_frame(arq_pkg::EV_SENT);
        end
        else if (op == arq_pkg::OP_LINE)
        begin
            if (rx_cnt < 35)
            begin
                rx_buf[rx_cnt] = b;
                rx_cnt++;
            end
            else
                rx_cnt = 36;
            rx_crc = crc16_step(rx_crc, b);
            if (e)
                rx_frame_done();
        end
        else if (op == arq_pkg::OP_TICK && awaiting)
        begin
            tmo = (tmo_reg == 0) ? 1 : int'(tmo_reg);
            if (wait_cnt != 16'hFFFF)
                wait_cnt++;
            if (int'(wait_cnt) >= tmo)
            begin
                wait_cnt = 16'h0000;
                resend_frame(arq_pkg::EV_TIMEOUT);
            end
        end
    endfunction

    // monitor: inputs first, then compare outputs in arrival order
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            int n0;
            n0 = expected_q.size();
            link_predict(operation, data_byte, end_mark);
            if (cur_typed)
            begin
                while (expected_q.size() > n0)
                    void'(expected_q.pop_back());
                push_res(arq_pkg::KIND_EVENT, 8'h00, cur_ev, 1'b1);
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            link_res_t x;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result kind=%0d byte=%h ev=%0d", kind, out_byte, event_res);
                errors++;
            end
            else
            begin
                x = expected_q.pop_front();
                if (kind !== x.kind)
                begin
                    $error("kind: expected %0d actual %0d", x.kind, kind);
                    errors++;
                end
                if (out_byte !== x.data)
                begin
                    $error("out_byte: expected %h actual %h", x.data, out_byte);
                    errors++;
                end
                if (event_res !== x.ev)
                begin
                    $error("event_res: expected %0d actual %0d", x.ev, event_res);
                    errors++;
                end
                if (last !== x.fin)
                begin
                    $error("last: expected %0d actual %0d", x.fin, last);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    function automatic void add_row(input logic [1:0] op, input logic [7:0] d,
                                    input logic e, input logic t, input logic [3:0] ev);
        stim_row_t r;
        r.op = op;
        r.data = d;
        r.endm = e;
        r.typed = t;
        r.ev = ev;
        stim_q.insert(stim_q.size(), r);
    endfunction

    // line frame: header, payload, CRC; optional corruption of one byte
    function automatic void add_frame(input logic [7:0] hdr, input int npay,
                                      input logic corrupt, input logic t, input logic [3:0] ev);
        logic [7:0]  fb[$];
        logic [15:0] c;
        int          k;
        fb.insert(fb.size(), hdr);
        for (int i = 0; i < npay; i++)
            fb.insert(fb.size(), 8'($urandom));
        c = 16'h0000;
        foreach (fb[i])
            c = crc16_step(c, fb[i]);
        fb.insert(fb.size(), c[15:8]);
        fb.insert(fb.size(), c[7:0]);
        if (corrupt)
        begin
            k = $urandom_range(fb.size() - 1);
            fb[k] = fb[k] ^ (8'd1 << $urandom_range(7));
        end
        // only the closing byte carries a typed result
        foreach (fb[i])
            add_row(arq_pkg::OP_LINE, fb[i], i == fb.size() - 1,
                    t && (i == fb.size() - 1), ev);
    endfunction

    // one random sequence, shaped by the current link state
    function automatic void make_block();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            n = awaiting ? 1 : $urandom_range(1, (lim_reg > 32 || lim_reg < 3) ? 6 : lim_reg + 1);
            for (int i = 0; i < n; i++)
                add_row(arq_pkg::OP_PAYLOAD, 8'($urandom),
                        (i == n - 1) && ($urandom_range(9) != 0), 1'b0, arq_pkg::EV_NONE);
        end
        else if (pick < 58)
        begin
            n = ($urandom_range(5) == 0) ? $urandom_range(20, 32) : $urandom_range(0, 4);
            if (awaiting)
                n = 0;
            add_frame({7'd0, ($urandom_range(4) == 0) ? ~seq_bit : seq_bit}, n,
                      1'b0, 1'b0, arq_pkg::EV_NONE);
        end
        else if (pick < 66)
            add_frame({7'd0, 1'($urandom)}, $urandom_range(0, 6), 1'b1, 1'b0, arq_pkg::EV_NONE);
        else if (pick < 70)
        begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                add_row(arq_pkg::OP_LINE, 8'($urandom), i == n - 1, 1'b0, arq_pkg::EV_NONE);
        end
        else if (pick < 73)
        begin
            n = $urandom_range(36, 40);
            for (int i = 0; i < n; i++)
                add_row(arq_pkg::OP_LINE, 8'($urandom), i == n - 1, 1'b0, arq_pkg::EV_NONE);
        end
        else if (pick < 95)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                add_row(arq_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b0, arq_pkg::EV_NONE);
        end
        else
            add_row(arq_pkg::OP_NONE, 8'($urandom), 1'($urandom), 1'b0, arq_pkg::EV_NONE);
    endfunction

    // feed queued rows, one transfer each, with random sender gaps
    task automatic drive_rows();
        stim_row_t r;
        while (stim_q.size() > 0)
        begin
            r = stim_q.pop_front();
            @(negedge clk);
            while ($urandom_range(99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            operation <= r.op;
            data_byte <= r.data;
            end_mark  <= r.endm;
            cur_typed <= r.typed;
            cur_ev    <= r.ev;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            if (r.op != arq_pkg::OP_NONE)
                items_sent++;
        end
        @(negedge clk);
        in_valid  <= 1'b0;
        cur_typed <= 1'b0;
    endtask

    // settle, then write both registers
    task automatic set_config(input logic [5:0] lim, input logic [15:0] tmo);
        while (expected_q.size() > 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= arq_pkg::CFG_LIMIT;
        cfg_data  <= {10'd0, lim};
        @(negedge clk);
        cfg_index <= arq_pkg::CFG_TIMEOUT;
        cfg_data  <= tmo;
        @(negedge clk);
        cfg_we    <= 1'b0;
        lim_reg = lim;
        tmo_reg = tmo;
    endtask

    task automatic random_phase(input int n_items, input int s_idle, input int r_idle);
        int goal;
        send_idle = s_idle;
        recv_idle = r_idle;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            make_block();
            drive_rows();
        end
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        send_idle = 0;
        recv_idle = 0;
        cur_typed = 1'b0;
        cur_ev = arq_pkg::EV_NONE;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = arq_pkg::OP_NONE;
        data_byte = 8'h00;
        end_mark = 1'b0;
        out_ready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = arq_pkg::CFG_LIMIT;
        cfg_data = 16'h0000;
        lim_reg = arq_pkg::PAYLOAD_LIMIT_RST;
        tmo_reg = arq_pkg::TIMEOUT_RST;
        seq_bit = 1'b0;
        awaiting = 1'b0;
        wait_cnt = 16'h0000;
        tx_len = 0;
        building = 1'b0;
        build_crc = 16'h0000;
        rx_cnt = 0;
        rx_crc = 16'h0000;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        set_config(6'd32, 16'd2);
        add_row(arq_pkg::OP_LINE, 8'h00, 1'b1, 1'b1, arq_pkg::EV_CRC);   // one-byte frame
        add_row(arq_pkg::OP_NONE, 8'hFF, 1'b1, 1'b0, arq_pkg::EV_NONE);  // ignored
        add_frame(8'h01, 1, 1'b0, 1'b1, arq_pkg::EV_SEQ);            // wrong header, none stored
        add_row(arq_pkg::OP_PAYLOAD, 8'hFF, 1'b0, 1'b0, arq_pkg::EV_NONE);
        add_row(arq_pkg::OP_PAYLOAD, 8'h00, 1'b1, 1'b0, arq_pkg::EV_NONE);   // frame goes out
        add_row(arq_pkg::OP_PAYLOAD, 8'h55, 1'b1, 1'b1, arq_pkg::EV_BUSY);   // refused
        add_row(arq_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, arq_pkg::EV_NONE);
        add_row(arq_pkg::OP_TICK, 8'hFF, 1'b1, 1'b0, arq_pkg::EV_NONE);      // timeout resend
        add_frame(8'h01, 0, 1'b0, 1'b1, arq_pkg::EV_SEQ);            // ACK with wrong header
        add_frame(8'h00, 0, 1'b1, 1'b1, arq_pkg::EV_CRC);            // corrupted ACK
        add_frame(8'h00, 0, 1'b0, 1'b1, arq_pkg::EV_ACK);            // good ACK
        add_frame(8'h01, 2, 1'b0, 1'b0, arq_pkg::EV_NONE);           // delivered
        add_frame(8'h01, 0, 1'b0, 1'b0, arq_pkg::EV_NONE);           // stale header, ACK resent
        for (int i = 0; i < 36; i++)
            add_row(arq_pkg::OP_LINE, 8'hA5, i == 35, i == 35, arq_pkg::EV_OVERFLOW);
        drive_rows();

        // random phases over several register settings
        set_config(6'd1, 16'd1);
        random_phase(55, 6, 61);
        set_config(6'd63, 16'hFFFF);
        random_phase(55, 61, 6);
        set_config(6'd0, 16'd0);
        random_phase(35, 0, 0);
        set_config(6'd7, 16'd3);
        random_phase(30, 0, 0);

        // drain
        while (expected_q.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (expected_q.size() > 0)
        begin
            $error("%0d expected results never arrived", expected_q.size());
            errors++;
        end
        $display("Covered %0d input transfers and %0d output transfers over five settings.",
                 items_sent, results_seen);
        if (errors == 0)
            $display("stop_and_wait_arq_link verification clean");
        else
            $display("stop_and_wait_arq_link verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #8ms;
        $display("stop_and_wait_arq_link verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/arq_pkg.sv
hdl/arq_ctrl.sv
hdl/arq_dp.sv
hdl/stop_and_wait_arq_link.sv
tb/testbench.sv
